// ----- hw/rtl/vurp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vurp_pkg: shared definitions of the video unit register port
// Command and register codes, field widths and default sizes.
// ----------------------------------------------------------------------------
package vurp_pkg;

  localparam int unsigned CmdW       = 2;
  localparam int unsigned BusAddrW   = 16;
  localparam int unsigned DataW      = 8;
  localparam int unsigned VramAddrW  = 15;
  localparam int unsigned FineXW     = 3;
  localparam int unsigned FlagsW     = 3;
  localparam int unsigned RegSelW    = 3;

  localparam int unsigned ObjectDepthDefault = 256;

  // The register window 0x2000..0x3FFF is selected by the top three bits.
  localparam logic [2:0] RegWindow = 3'b001;

  typedef enum logic [CmdW-1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_STATUS = 2'd2
  } cmd_e;

  typedef enum logic [RegSelW-1:0] {
    REG_CTRL     = 3'd0,
    REG_MASK     = 3'd1,
    REG_STATUS   = 3'd2,
    REG_OBJ_ADDR = 3'd3,
    REG_OBJ_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_ADDR     = 3'd6,
    REG_DATA     = 3'd7
  } reg_e;

endpackage

// ----- hw/rtl/vurp_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vurp_req_if: request channel of the video unit register port
// Carries one bus access or status update per transaction.
// ----------------------------------------------------------------------------
interface vurp_req_if;
  logic                          valid;
  logic                          ready;
  logic [vurp_pkg::CmdW-1:0]     cmd;
  logic [vurp_pkg::BusAddrW-1:0] bus_addr;
  logic [vurp_pkg::DataW-1:0]    write_data;

  modport source (output valid, output cmd, output bus_addr, output write_data,
                  input ready);
  modport sink   (input valid, input cmd, input bus_addr, input write_data,
                  output ready);
endinterface

// ----- hw/rtl/vurp_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vurp_rsp_if: response channel of the video unit register port
// Carries the read byte and the register view after each access.
// ----------------------------------------------------------------------------
interface vurp_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [vurp_pkg::DataW-1:0]     read_data;
  logic [vurp_pkg::VramAddrW-1:0] vram_address;
  logic [vurp_pkg::FineXW-1:0]    fine_scroll_x;
  logic [vurp_pkg::DataW-1:0]     control_value;
  logic [vurp_pkg::DataW-1:0]     mask_value;

  modport source (output valid, output read_data, output vram_address,
                  output fine_scroll_x, output control_value, output mask_value,
                  input ready);
  modport sink   (input valid, input read_data, input vram_address,
                  input fine_scroll_x, input control_value, input mask_value,
                  output ready);
endinterface

// ----- hw/rtl/vurp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vurp_ram: generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vurp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is requested.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/video_unit_register_port.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_unit_register_port: CPU-side register file of a picture unit
// Decodes bus reads and writes onto the eight mirrored picture unit registers.
// ----------------------------------------------------------------------------
// Every transaction on req_i is decoded and applied to the register state at
// the edge where it is accepted, and its response is held in an output
// register on rsp_o in the following cycle. A new transaction can be
// accepted in every cycle, as long as the previous response is taken in that
// same cycle or has already gone. Bus addresses 0x2000..0x3FFF map onto the
// registers by their low three bits; anything else reads zero and ignores
// writes. Command 2 loads the status flags (vblank, sprite zero hit, sprite
// overflow) from write_data bits 7..5. The vram_address, fine_scroll_x,
// control_value and mask_value fields always show the state after the
// transaction that the response belongs to. The object memory sits in a RAM
// with registered read; one valid flip-flop per entry makes never-written
// entries read as zero straight out of reset, so no clearing pass is needed.
// The data port, object DMA and rendering itself are not part of this block.
// ----------------------------------------------------------------------------
module video_unit_register_port #(
  parameter int unsigned OBJECT_DEPTH = vurp_pkg::ObjectDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  vurp_req_if.sink   req_i,
  vurp_rsp_if.source rsp_o
);
  import vurp_pkg::*;

  localparam int unsigned ObjAw = $clog2(OBJECT_DEPTH);

  // Architectural register state.
  logic [DataW-1:0]     control_q, control_d;
  logic [DataW-1:0]     mask_q, mask_d;
  logic [FlagsW-1:0]    flags_q, flags_d;
  logic [ObjAw-1:0]     obj_ptr_q, obj_ptr_d;
  logic [VramAddrW-1:0] temp_q, temp_d;
  logic [VramAddrW-1:0] cur_q, cur_d;
  logic [FineXW-1:0]    fine_x_q, fine_x_d;
  logic                 toggle_q, toggle_d;
  logic [OBJECT_DEPTH-1:0] obj_vld_q;

  // Response register.
  logic             rsp_valid_q;
  logic [DataW-1:0] rd_q, rd_d;
  logic             obj_rd_q, obj_rd_d;
  logic             obj_hit_q;

  logic             accept;
  logic             mapped;
  cmd_e             cmd;
  reg_e             sel;
  logic [DataW-1:0] wdata;
  logic             obj_we;
  logic [DataW-1:0] ram_rdata;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign cmd    = cmd_e'(req_i.cmd);
  assign sel    = reg_e'(req_i.bus_addr[RegSelW-1:0]);
  assign wdata  = req_i.write_data;
  assign mapped = (req_i.bus_addr[BusAddrW-1 -: 3] == RegWindow);

  // Decode and next-state logic for one transaction.
  always_comb begin
    control_d = control_q;
    mask_d    = mask_q;
    flags_d   = flags_q;
    obj_ptr_d = obj_ptr_q;
    temp_d    = temp_q;
    cur_d     = cur_q;
    fine_x_d  = fine_x_q;
    toggle_d  = toggle_q;
    rd_d      = '0;
    obj_rd_d  = 1'b0;
    obj_we    = 1'b0;

    case (cmd)
      CMD_READ: begin
        if (mapped) begin
          case (sel)
            REG_STATUS: begin
              // Flags come out in the top bits; reading clears vblank and
              // restarts the two-write sequences.
              rd_d     = {flags_q, {(DataW - FlagsW){1'b0}}};
              flags_d  = {1'b0, flags_q[FlagsW-2:0]};
              toggle_d = 1'b0;
            end
            REG_OBJ_DATA: begin
              obj_rd_d = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      CMD_WRITE: begin
        if (mapped) begin
          case (sel)
            REG_CTRL: begin
              control_d       = wdata;
              temp_d[11:10]   = wdata[1:0];
            end
            REG_MASK: begin
              mask_d = wdata;
            end
            REG_OBJ_ADDR: begin
              obj_ptr_d = ObjAw'(wdata);
            end
            REG_OBJ_DATA: begin
              obj_we    = 1'b1;
              obj_ptr_d = obj_ptr_q + 1'b1;
            end
            REG_SCROLL: begin
              if (toggle_q) begin
                // Second write: fine Y and coarse Y.
                temp_d[14:12] = wdata[2:0];
                temp_d[9:5]   = wdata[7:3];
              end else begin
                // First write: coarse X and fine X.
                temp_d[4:0] = wdata[7:3];
                fine_x_d    = wdata[2:0];
              end
              toggle_d = !toggle_q;
            end
            REG_ADDR: begin
              if (toggle_q) begin
                temp_d[7:0] = wdata;
                cur_d       = {temp_q[14:8], wdata};
              end else begin
                // High byte; the top address bit is always cleared.
                temp_d[14:8] = {1'b0, wdata[5:0]};
              end
              toggle_d = !toggle_q;
            end
            default: begin
            end
          endcase
        end
      end
      CMD_STATUS: begin
        flags_d = wdata[DataW-1 -: FlagsW];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q <= '0;
      mask_q    <= '0;
      flags_q   <= '0;
      obj_ptr_q <= '0;
      temp_q    <= '0;
      cur_q     <= '0;
      fine_x_q  <= '0;
      toggle_q  <= 1'b0;
      obj_vld_q <= '0;
    end else if (accept) begin
      control_q <= control_d;
      mask_q    <= mask_d;
      flags_q   <= flags_d;
      obj_ptr_q <= obj_ptr_d;
      temp_q    <= temp_d;
      cur_q     <= cur_d;
      fine_x_q  <= fine_x_d;
      toggle_q  <= toggle_d;
      if (obj_we) begin
        obj_vld_q[obj_ptr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      rsp_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q      <= rd_d;
      obj_rd_q  <= obj_rd_d;
      obj_hit_q <= obj_vld_q[obj_ptr_q];
    end
  end

  // Object memory: written and read at the pointer held before the access.
  vurp_ram #(
    .Width (DataW),
    .Depth (OBJECT_DEPTH)
  ) u_obj_ram (
    .clk_i   (clk_i),
    .we_i    (accept && obj_we),
    .waddr_i (obj_ptr_q),
    .wdata_i (wdata),
    .re_i    (accept && obj_rd_d),
    .raddr_i (obj_ptr_q),
    .rdata_o (ram_rdata)
  );

  // While a response waits, no transaction is accepted, so the state
  // registers still show the state right after that response's access.
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.read_data     = obj_rd_q ? (obj_hit_q ? ram_rdata : '0) : rd_q;
  assign rsp_o.vram_address  = cur_q;
  assign rsp_o.fine_scroll_x = fine_x_q;
  assign rsp_o.control_value = control_q;
  assign rsp_o.mask_value    = mask_q;

endmodule
